[design/mfe_pkg.sv]
// constants and types shared by the meter frame encoder files
package mfe_pkg;

  localparam int unsigned AddrBytes = 6;
  localparam int unsigned AddrW = 8 * AddrBytes;

  localparam logic [7:0] MaxPayloadDefault = 8'd200;

  localparam logic [7:0] WakeByte   = 8'hFE;
  localparam logic [7:0] StartByte  = 8'h68;
  localparam logic [7:0] DataOffset = 8'h33;
  localparam logic [7:0] EndByte    = 8'h16;
  localparam logic [7:0] SumSeed    = 8'hD0;

  localparam logic ModeHeader  = 1'b0;
  localparam logic ModePayload = 1'b1;

  // beat positions inside a header burst
  localparam logic [3:0] BeatWake0  = 4'd0;
  localparam logic [3:0] BeatWake3  = 4'd3;
  localparam logic [3:0] BeatStart1 = 4'd4;
  localparam logic [3:0] BeatAddr0  = 4'd5;
  localparam logic [3:0] BeatAddr5  = 4'd10;
  localparam logic [3:0] BeatStart2 = 4'd11;
  localparam logic [3:0] BeatCtrl   = 4'd12;
  localparam logic [3:0] BeatLen    = 4'd13;
  localparam logic [3:0] BeatSum    = 4'd14;
  localparam logic [3:0] BeatEnd    = 4'd15;

  // beat positions inside a payload burst
  localparam logic [3:0] PayData = 4'd0;
  localparam logic [3:0] PaySum  = 4'd1;
  localparam logic [3:0] PayEnd  = 4'd2;

  typedef struct packed {
    logic             mode;
    logic [AddrW-1:0] meter_address;
    logic [7:0]       control_code;
    logic [7:0]       payload_length;
    logic [7:0]       payload_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       seq_error;
  } beat_t;

endpackage

[design/mfe_channels.sv]
// valid/ready channel interfaces for the item input and the byte output
interface mfe_item_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [mfe_pkg::AddrW-1:0] meter_address;
  logic [7:0]               control_code;
  logic [7:0]               payload_length;
  logic [7:0]               payload_byte;

  modport source (
    output valid, mode, meter_address, control_code, payload_length, payload_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, meter_address, control_code, payload_length, payload_byte,
    output ready
  );
endinterface

interface mfe_beat_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_end;
  logic       seq_error;

  modport source (
    output valid, tx_byte, frame_end, seq_error,
    input  ready
  );
  modport sink (
    input  valid, tx_byte, frame_end, seq_error,
    output ready
  );
endinterface

[design/meter_frame_encoder.sv]
// meter frame encoder: turns header and payload items into a framed byte stream
//
// item_i takes one item per beat: a header (mode 0) or one payload byte (mode 1).
// beat_o gives one frame byte per beat, with frame_end on the closing 0x16 and
// seq_error on a payload byte that arrives with no open frame.
// an accepted item sits in an item register; a sequencer walks its bytes one
// per cycle into the output register while the receiver does not stall, so the
// bytes of an item pass through the item register and then the output register.
// a header item gives 14 bytes (16 when its length is zero, which closes the
// frame at once); a payload item gives 1 byte, 3 for the last byte of a frame
// (data, checksum, 0x16); an error gives 1 beat. the next item is taken in the
// same cycle the last byte of the current one moves to the output register, so
// payload streams at one byte per cycle while the receiver does not stall.
// lengths above MAX_PAYLOAD are clamped; a header abandons any open frame.
// reset clears the running checksum, the byte count and the open-frame flag and
// empties both registers.
// when the receiver stalls the output register holds its byte, the sequencer
// stops and item_i drops ready once the item register is occupied.
module meter_frame_encoder #(
  parameter logic [7:0] MAX_PAYLOAD = mfe_pkg::MaxPayloadDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mfe_item_if.sink       item_i,
  mfe_beat_if.source     beat_o
);

  mfe_pkg::item_t item_q;
  logic           cur_valid_q;
  logic [3:0]     idx_q;
  logic [7:0]     sum_q, sum_d;
  logic [7:0]     left_q, left_d;
  logic           open_q, open_d;
  mfe_pkg::beat_t out_q, beat;
  logic           out_valid_q;
  logic           step, last, accept;
  logic [7:0]     len_clamped;
  logic [mfe_pkg::AddrBytes-1:0][7:0] addr_bytes;
  logic [2:0]     addr_sel;

  assign len_clamped = (item_i.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                             : item_i.payload_length;
  assign step   = cur_valid_q && (!out_valid_q || beat_o.ready);
  assign item_i.ready = !cur_valid_q || (step && last);
  assign accept = item_i.valid && item_i.ready;

  assign addr_bytes = item_q.meter_address;
  assign addr_sel   = 3'(idx_q - mfe_pkg::BeatAddr0);

  always_comb begin
    beat   = '0;
    sum_d  = sum_q;
    left_d = left_q;
    open_d = open_q;
    last   = 1'b0;
    if (item_q.mode == mfe_pkg::ModeHeader) begin
      case (idx_q) inside
        [mfe_pkg::BeatWake0:mfe_pkg::BeatWake3]: begin
          beat.tx_byte = mfe_pkg::WakeByte;
        end
        mfe_pkg::BeatStart1: begin
          beat.tx_byte = mfe_pkg::StartByte;
          sum_d        = mfe_pkg::SumSeed;
        end
        [mfe_pkg::BeatAddr0:mfe_pkg::BeatAddr5]: begin
          beat.tx_byte = addr_bytes[addr_sel];
          sum_d        = sum_q + addr_bytes[addr_sel];
        end
        mfe_pkg::BeatStart2: begin
          beat.tx_byte = mfe_pkg::StartByte;
        end
        mfe_pkg::BeatCtrl: begin
          beat.tx_byte = item_q.control_code;
          sum_d        = sum_q + item_q.control_code;
        end
        mfe_pkg::BeatLen: begin
          beat.tx_byte = item_q.payload_length;
          sum_d        = sum_q + item_q.payload_length;
          left_d       = item_q.payload_length;
          open_d       = 1'b1;
          last         = (item_q.payload_length != 8'd0);
        end
        mfe_pkg::BeatSum: begin
          beat.tx_byte = sum_q;
        end
        default: begin
          beat.tx_byte   = mfe_pkg::EndByte;
          beat.frame_end = 1'b1;
          open_d         = 1'b0;
          left_d         = 8'd0;
          last           = 1'b1;
        end
      endcase
    end else begin
      case (idx_q)
        mfe_pkg::PayData: begin
          if (!open_q || left_q == 8'd0) begin
            beat.seq_error = 1'b1;
            last           = 1'b1;
          end else begin
            beat.tx_byte = item_q.payload_byte + mfe_pkg::DataOffset;
            sum_d        = sum_q + item_q.payload_byte + mfe_pkg::DataOffset;
            left_d       = left_q - 8'd1;
            last         = (left_q != 8'd1);
          end
        end
        mfe_pkg::PaySum: begin
          beat.tx_byte = sum_q;
        end
        mfe_pkg::PayEnd: begin
          beat.tx_byte   = mfe_pkg::EndByte;
          beat.frame_end = 1'b1;
          open_d         = 1'b0;
          left_d         = 8'd0;
          last           = 1'b1;
        end
        default: begin
          last = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      sum_q       <= '0;
      left_q      <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        sum_q  <= sum_d;
        left_q <= left_d;
        open_q <= open_d;
      end
      if (accept) begin
        idx_q <= 4'd0;
      end else if (step) begin
        idx_q <= last ? 4'd0 : idx_q + 4'd1;
      end
      if (accept) begin
        cur_valid_q <= 1'b1;
      end else if (step && last) begin
        cur_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (beat_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.mode           <= item_i.mode;
      item_q.meter_address  <= item_i.meter_address;
      item_q.control_code   <= item_i.control_code;
      item_q.payload_length <= len_clamped;
      item_q.payload_byte   <= item_i.payload_byte;
    end
    if (step) begin
      out_q <= beat;
    end
  end

  assign beat_o.valid     = out_valid_q;
  assign beat_o.tx_byte   = out_q.tx_byte;
  assign beat_o.frame_end = out_q.frame_end;
  assign beat_o.seq_error = out_q.seq_error;

endmodule

[design/mfe_checker.sv]
// port-level assertions for the meter frame encoder, bound to the top level
module mfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] tx_byte_i,
  input logic       frame_end_i,
  input logic       seq_error_i
);

  // a stalled beat stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(tx_byte_i))
    else $error("output byte changed while stalled");

  // closing byte and error never share a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(frame_end_i && seq_error_i))
    else $error("frame end and sequence error on one beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> tx_byte_i == mfe_pkg::EndByte)
    else $error("frame end on a byte other than the end byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seq_error_i |-> tx_byte_i == 8'd0)
    else $error("error beat carries a nonzero byte");

endmodule

bind meter_frame_encoder mfe_checker u_mfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (beat_o.valid),
  .out_ready_i (beat_o.ready),
  .tx_byte_i   (beat_o.tx_byte),
  .frame_end_i (beat_o.frame_end),
  .seq_error_i (beat_o.seq_error)
);

[tb/meter_frame_encoder_tb.sv]
// self-checking testbench for the meter frame encoder with random handshake stalls
`timescale 1ns / 1ps

module meter_frame_encoder_tb;

  localparam logic [7:0] MaxPayload = mfe_pkg::MaxPayloadDefault;
  localparam int unsigned IdleLimit = 4000;

  logic clk_i = 1'b0;
  logic rst_ni;

  mfe_item_if item_if ();
  mfe_beat_if beat_if ();

  meter_frame_encoder #(
    .MAX_PAYLOAD(MaxPayload)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(item_if),
    .beat_o(beat_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted frame bytes, oldest first
  mfe_pkg::beat_t frame_bytes_q[$];

  logic [7:0]  sum_acc;
  logic [7:0]  left_cnt;
  logic        open_flag;
  int unsigned mismatch_cnt;
  bit          src_quiet;
  bit          snk_quiet;
  int unsigned idle_cycles;

  function automatic void push_beat(input logic [7:0] b, input logic e, input logic s);
    mfe_pkg::beat_t bt;
    bt.tx_byte   = b;
    bt.frame_end = e;
    bt.seq_error = s;
    frame_bytes_q.push_back(bt);
  endfunction

  function automatic void close_frame();
    push_beat(sum_acc, 1'b0, 1'b0);
    push_beat(mfe_pkg::EndByte, 1'b1, 1'b0);
    open_flag = 1'b0;
    left_cnt  = 8'd0;
  endfunction

  function automatic void encode_item(input mfe_pkg::item_t it);
    logic [7:0] len;
    logic [7:0] b;
    logic [7:0] sum;
    if (it.mode == mfe_pkg::ModeHeader) begin
      len = (it.payload_length > MaxPayload) ? MaxPayload : it.payload_length;
      sum = mfe_pkg::SumSeed;
      for (int i = 0; i < 4; i++) push_beat(mfe_pkg::WakeByte, 1'b0, 1'b0);
      push_beat(mfe_pkg::StartByte, 1'b0, 1'b0);
      for (int i = 0; i < mfe_pkg::AddrBytes; i++) begin
        b   = it.meter_address[8*i +: 8];
        sum = sum + b;
        push_beat(b, 1'b0, 1'b0);
      end
      push_beat(mfe_pkg::StartByte, 1'b0, 1'b0);
      sum = sum + it.control_code;
      push_beat(it.control_code, 1'b0, 1'b0);
      sum = sum + len;
      push_beat(len, 1'b0, 1'b0);
      sum_acc   = sum;
      left_cnt  = len;
      open_flag = 1'b1;
      if (len == 8'd0) close_frame();
    end else if (!open_flag || left_cnt == 8'd0) begin
      push_beat(8'd0, 1'b0, 1'b1);
    end else begin
      b        = it.payload_byte + mfe_pkg::DataOffset;
      sum_acc  = sum_acc + b;
      push_beat(b, 1'b0, 1'b0);
      left_cnt = left_cnt - 8'd1;
      if (left_cnt == 8'd0) close_frame();
    end
  endfunction

  function automatic logic [mfe_pkg::AddrW-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[mfe_pkg::AddrW-1:0];
  endfunction

  function automatic mfe_pkg::item_t make_header(input logic [mfe_pkg::AddrW-1:0] addr,
                                                 input logic [7:0] ctrl,
                                                 input logic [7:0] len);
    mfe_pkg::item_t it;
    it.mode           = mfe_pkg::ModeHeader;
    it.meter_address  = addr;
    it.control_code   = ctrl;
    it.payload_length = len;
    it.payload_byte   = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic mfe_pkg::item_t make_payload(input logic [7:0] b);
    mfe_pkg::item_t it;
    it.mode           = mfe_pkg::ModePayload;
    it.meter_address  = rand_addr();
    it.control_code   = 8'($urandom_range(0, 255));
    it.payload_length = 8'($urandom_range(0, 255));
    it.payload_byte   = b;
    return it;
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_item(input mfe_pkg::item_t it);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid          <= 1'b1;
    item_if.mode           <= it.mode;
    item_if.meter_address  <= it.meter_address;
    item_if.control_code   <= it.control_code;
    item_if.payload_length <= it.payload_length;
    item_if.payload_byte   <= it.payload_byte;
    do @(posedge clk_i); while (!item_if.ready);
    encode_item(it);
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (frame_bytes_q.size() != 0);
  endtask

  task automatic send_frame(input logic [7:0] len, input int unsigned n_data);
    send_item(make_header(rand_addr(), 8'($urandom_range(0, 255)), len));
    repeat (n_data) send_item(make_payload(8'($urandom_range(0, 255))));
  endtask

  task automatic test_stray_payload();
    send_item(make_payload(8'hFF));
    send_item(make_payload(8'h00));
  endtask

  task automatic test_empty_frame();
    send_item(make_header({mfe_pkg::AddrW{1'b1}}, 8'hFF, 8'd0));
    send_item(make_header('0, 8'h00, 8'd0));
    wait_drained();
  endtask

  task automatic test_short_frames();
    send_item(make_header('0, 8'h00, 8'd1));
    send_item(make_payload(8'hCD));
    send_item(make_payload(8'h5A));
    send_item(make_header(48'h0123_4567_89AB, 8'h55, 8'd2));
    send_item(make_payload(8'h00));
    send_item(make_payload(8'hFF));
  endtask

  task automatic test_clamp_and_abandon();
    send_item(make_header(48'hFFFF_0000_FFFF, 8'hAA, 8'd255));
    send_item(make_payload(8'h12));
    send_item(make_payload(8'hFE));
    send_item(make_header(48'h5555_AAAA_5555, 8'h11, 8'd201));
    send_item(make_header(48'hA5A5_5A5A_A5A5, 8'h91, 8'd0));
    send_item(make_payload(8'h80));
    wait_drained();
  endtask

  task automatic test_max_frame();
    send_item(make_header(rand_addr(), 8'($urandom_range(0, 255)),
                          8'($urandom_range(200, 255))));
    src_quiet = 1'b1;
    snk_quiet = 1'b1;
    repeat (120) send_item(make_payload(8'($urandom_range(0, 255))));
    snk_quiet = 1'b0;
    repeat (80) send_item(make_payload(8'($urandom_range(0, 255))));
    src_quiet = 1'b0;
    send_item(make_payload(8'($urandom_range(0, 255))));
    wait_drained();
  endtask

  task automatic test_random_frames(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    sent = 0;
    while (sent < n_items) begin
      src_quiet = ($urandom_range(0, 3) == 0);
      snk_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_item(make_payload(8'($urandom_range(0, 255))));
        sent += 1;
      end else if (pick == 1) begin
        // broken frame: fewer payload beats than announced
        len = $urandom_range(1, 255);
        cut = $urandom_range(0, (len > 12) ? 12 : len - 1);
        send_frame(8'(len), cut);
        sent += cut + 1;
      end else begin
        len = $urandom_range(0, 12);
        send_frame(8'(len), len);
        sent += len + 1;
      end
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
    src_quiet = 1'b0;
    snk_quiet = 1'b0;
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    item_if.valid          <= 1'b0;
    item_if.mode           <= mfe_pkg::ModeHeader;
    item_if.meter_address  <= '0;
    item_if.control_code   <= 8'd0;
    item_if.payload_length <= 8'd0;
    item_if.payload_byte   <= 8'd0;
    sum_acc      = 8'd0;
    left_cnt     = 8'd0;
    open_flag    = 1'b0;
    mismatch_cnt = 0;
    src_quiet    = 1'b0;
    snk_quiet    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_stray_payload();
    test_empty_frame();
    test_short_frames();
    test_clamp_and_abandon();
    test_max_frame();
    test_random_frames(215);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("meter_frame_encoder regression: pass");
    end else begin
      $display("meter_frame_encoder regression: fail");
    end
    $finish;
  end

  // output side: random stalls, then compare each beat with the oldest prediction
  initial begin
    int unsigned    stall;
    mfe_pkg::beat_t exp_beat;
    beat_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = snk_quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        beat_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      beat_if.ready <= 1'b1;
      do @(posedge clk_i); while (beat_if.valid !== 1'b1);
      if (frame_bytes_q.size() == 0) begin
        $error("unexpected beat: tx_byte %0h frame_end %0b seq_error %0b",
               beat_if.tx_byte, beat_if.frame_end, beat_if.seq_error);
        mismatch_cnt += 1;
      end else begin
        exp_beat = frame_bytes_q.pop_front();
        if (beat_if.tx_byte !== exp_beat.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", exp_beat.tx_byte, beat_if.tx_byte);
          mismatch_cnt += 1;
        end
        if (beat_if.frame_end !== exp_beat.frame_end) begin
          $error("frame_end: expected %0b, got %0b", exp_beat.frame_end, beat_if.frame_end);
          mismatch_cnt += 1;
        end
        if (beat_if.seq_error !== exp_beat.seq_error) begin
          $error("seq_error: expected %0b, got %0b", exp_beat.seq_error, beat_if.seq_error);
          mismatch_cnt += 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (item_if.valid && item_if.ready) ||
        (beat_if.valid && beat_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("meter_frame_encoder regression: fail");
      $finish;
    end
  end

endmodule
